// ----- src/vsp_pkg.sv -----
// Package for the varispeed sample player: widths, limits, codes and types.
// Used by every module of the block; depends on nothing.
package vsp_pkg;

  localparam int ADDR_W       = 16;
  localparam int SAMPLE_DEPTH = 1 << ADDR_W;
  localparam int LOAD_W       = ADDR_W + 1;
  localparam int MAX_BLOCK    = 64;
  localparam int COUNT_W      = 7;
  localparam int SAMPLE_W     = 16;
  localparam int FRAME_W      = 2 * SAMPLE_W;
  localparam int GAIN_W       = 16;
  localparam int STEP_W       = 22;
  localparam int FRAC_W       = 16;
  localparam int ACC_W        = 28;
  localparam int OFFS_W       = ACC_W - FRAC_W;
  localparam int POS_W        = 17;
  localparam int LEN_W        = 17;
  localparam int CFG_W        = 22;
  localparam int IDX_W        = 2;

  localparam logic [STEP_W-1:0] PITCH_MIN   = STEP_W'(7);
  localparam logic [STEP_W-1:0] PITCH_MAX   = STEP_W'(2097152);
  localparam logic [STEP_W-1:0] PITCH_RESET = STEP_W'(65536);
  localparam logic [GAIN_W-1:0] GAIN_UNITY  = GAIN_W'(32768);

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_RENDER = 2'd2;

  localparam logic [IDX_W-1:0] CFG_PITCH  = IDX_W'(0);
  localparam logic [IDX_W-1:0] CFG_GAIN   = IDX_W'(1);
  localparam logic [IDX_W-1:0] CFG_LENGTH = IDX_W'(2);

  typedef enum logic [1:0] {
    MODE_INIT = 2'd0,
    MODE_PROC = 2'd1,
    MODE_DONE = 2'd2
  } play_mode_t;

  typedef struct packed {
    logic               wr_en;
    logic [ADDR_W-1:0]  waddr;
    logic [FRAME_W-1:0] wdata;
    logic               rd_en;
    logic [ADDR_W-1:0]  raddr;
  } store_req_t;

endpackage

// ----- src/vsp_scale.sv -----
// Shared gain multiplier with a registered product and round-half-up output.
// Depends on vsp_pkg.
module vsp_scale (
  input  logic                              clk,
  input  logic signed [vsp_pkg::SAMPLE_W-1:0] sample,
  input  logic        [vsp_pkg::GAIN_W-1:0]   gain,
  output logic signed [vsp_pkg::SAMPLE_W-1:0] result
);

  localparam int PROD_W = vsp_pkg::SAMPLE_W + vsp_pkg::GAIN_W + 1;
  localparam int SHIFT  = vsp_pkg::GAIN_W - 1;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rounded;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(sample) * PROD_W'($signed({1'b0, gain}));
  end

  assign rounded = prod + PROD_W'(1 << (SHIFT - 1));
  assign result  = rounded[SHIFT + vsp_pkg::SAMPLE_W - 1:SHIFT];

endmodule

// ----- src/vsp_store.sv -----
// Frame store: one write port and one registered read port.
// Depends on vsp_pkg for the address width and the request struct.
module vsp_store (
  input  logic                          clk,
  input  vsp_pkg::store_req_t           req,
  output logic [vsp_pkg::FRAME_W-1:0]   rdata
);

  logic [vsp_pkg::FRAME_W-1:0] mem [vsp_pkg::SAMPLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ----- src/varispeed_sample_player.sv -----
// Varispeed stereo sample player, top level with the control sequencer.
// Depends on vsp_pkg, vsp_scale and vsp_store.
//
// Input items arrive on s_tvalid/s_tready with the opcode in s_tuser and the
// samples and block size in s_tdata. Result frames leave on m_tvalid/m_tready
// with the samples in m_tdata, the final frame of a block marked by m_tlast
// and frames past the play length marked by m_tuser.
// Registers are written through cfg_valid/cfg_index/cfg_data; cfg_ready is
// always high, and writes are expected only while the block is idle.
// A load item passes through S_MUL_L, S_MUL_R and S_WRITE: the shared multiplier
// scales the left and then the right sample, and the frame is written in S_WRITE.
// A start item, an ignored render and an unused opcode are done in S_IDLE alone.
// A render item of N frames, at most 64, passes each frame through S_READ for
// the store read and S_EMIT, where it waits in the output register until taken.
// The block takes no new item until all frames of a render have been taken.
// When the receiver stalls, the current frame is held in place and the
// sequencer waits. Reset restores the register defaults and clears the load
// address, the play position and the mode; the store itself is not cleared and needs no pass.
module varispeed_sample_player (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // left_in [15:0], right_in [31:16], block_frames [38:32], zero pad [39]
  input  logic [39:0]                   s_tdata,
  // opcode [1:0]
  input  logic [1:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // left_out [15:0], right_out [31:16]
  output logic [31:0]                   m_tdata,
  output logic                          m_tlast,
  // ended [0]
  output logic                          m_tuser,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vsp_pkg::IDX_W-1:0]     cfg_index,
  input  logic [vsp_pkg::CFG_W-1:0]     cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL_L = 6'b000010,
    S_MUL_R = 6'b000100,
    S_WRITE = 6'b001000,
    S_READ  = 6'b010000,
    S_EMIT  = 6'b100000
  } seq_state_t;

  seq_state_t                          state;
  vsp_pkg::play_mode_t                 play_mode;
  logic [vsp_pkg::LOAD_W-1:0]          load_address;
  logic [vsp_pkg::POS_W-1:0]           play_position;
  logic [vsp_pkg::STEP_W-1:0]          pitch_step;
  logic [vsp_pkg::GAIN_W-1:0]          gain;
  logic [vsp_pkg::LEN_W-1:0]           play_length;
  logic signed [vsp_pkg::SAMPLE_W-1:0] left_in;
  logic signed [vsp_pkg::SAMPLE_W-1:0] right_in;
  logic signed [vsp_pkg::SAMPLE_W-1:0] left_scaled;
  logic [vsp_pkg::COUNT_W-1:0]         frames;
  logic [vsp_pkg::COUNT_W-1:0]         frame_cnt;
  logic [vsp_pkg::ACC_W-1:0]           acc;
  logic                                ended;
  logic                                at_end;

  logic [vsp_pkg::STEP_W-1:0]          step_c;
  logic [vsp_pkg::GAIN_W-1:0]          gain_c;
  logic [vsp_pkg::LEN_W-1:0]           len_c;
  logic [vsp_pkg::COUNT_W-1:0]         frames_in;
  logic [vsp_pkg::COUNT_W-1:0]         frames_c;
  logic [vsp_pkg::ACC_W-1:0]           acc_next;
  logic [vsp_pkg::OFFS_W-1:0]          offs_next;
  logic [vsp_pkg::POS_W:0]             addr_sum;
  logic                                past;
  logic                                in_acc;
  logic                                out_acc;
  logic                                last_frame;
  logic signed [vsp_pkg::SAMPLE_W-1:0] mul_sample;
  logic signed [vsp_pkg::SAMPLE_W-1:0] mul_result;
  logic [vsp_pkg::FRAME_W-1:0]         rdata;
  vsp_pkg::store_req_t                 store_req;

  always_comb begin
    if (pitch_step < vsp_pkg::PITCH_MIN) begin
      step_c = vsp_pkg::PITCH_MIN;
    end else if (pitch_step > vsp_pkg::PITCH_MAX) begin
      step_c = vsp_pkg::PITCH_MAX;
    end else begin
      step_c = pitch_step;
    end
  end

  assign gain_c    = (gain > vsp_pkg::GAIN_UNITY) ? vsp_pkg::GAIN_UNITY : gain;
  assign len_c     = (play_length > vsp_pkg::LEN_W'(vsp_pkg::SAMPLE_DEPTH))
                     ? vsp_pkg::LEN_W'(vsp_pkg::SAMPLE_DEPTH) : play_length;
  assign frames_in = s_tdata[38:32];
  assign frames_c  = (frames_in > vsp_pkg::COUNT_W'(vsp_pkg::MAX_BLOCK))
                     ? vsp_pkg::COUNT_W'(vsp_pkg::MAX_BLOCK) : frames_in;

  assign in_acc     = s_tvalid && s_tready;
  assign out_acc    = m_tvalid && m_tready;
  assign last_frame = (vsp_pkg::COUNT_W'(frame_cnt + 1'b1) == frames);

  assign acc_next  = ended ? acc : vsp_pkg::ACC_W'(acc + vsp_pkg::ACC_W'(step_c));
  assign offs_next = acc_next[vsp_pkg::ACC_W-1:vsp_pkg::FRAC_W];
  assign addr_sum  = {1'b0, play_position}
                     + (vsp_pkg::POS_W + 1)'(acc[vsp_pkg::ACC_W-1:vsp_pkg::FRAC_W]);
  assign past      = (addr_sum >= {1'b0, len_c});

  assign mul_sample = (state == S_MUL_L) ? left_in : right_in;

  vsp_scale u_scale (
    .clk    (clk),
    .sample (mul_sample),
    .gain   (gain_c),
    .result (mul_result)
  );

  always_comb begin
    store_req.wr_en = (state == S_WRITE)
                      && (load_address < vsp_pkg::LOAD_W'(vsp_pkg::SAMPLE_DEPTH));
    store_req.waddr = load_address[vsp_pkg::ADDR_W-1:0];
    store_req.wdata = {mul_result, left_scaled};
    store_req.rd_en = (state == S_READ);
    store_req.raddr = addr_sum[vsp_pkg::ADDR_W-1:0];
  end

  vsp_store u_store (
    .clk   (clk),
    .req   (store_req),
    .rdata (rdata)
  );

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid  = (state == S_EMIT);
  assign m_tdata   = ended ? '0 : rdata;
  assign m_tlast   = last_frame;
  assign m_tuser   = ended;

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_step  <= vsp_pkg::PITCH_RESET;
      gain        <= vsp_pkg::GAIN_UNITY;
      play_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vsp_pkg::CFG_PITCH:  pitch_step  <= cfg_data[vsp_pkg::STEP_W-1:0];
        vsp_pkg::CFG_GAIN:   gain        <= cfg_data[vsp_pkg::GAIN_W-1:0];
        vsp_pkg::CFG_LENGTH: play_length <= cfg_data[vsp_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      play_mode     <= vsp_pkg::MODE_INIT;
      load_address  <= '0;
      play_position <= '0;
      frame_cnt     <= '0;
      ended         <= 1'b0;
      at_end        <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            left_in  <= s_tdata[15:0];
            right_in <= s_tdata[31:16];
            frames   <= frames_c;
            acc       <= '0;
            frame_cnt <= '0;
            at_end    <= 1'b0;
            case (s_tuser)
              vsp_pkg::OP_LOAD: state <= S_MUL_L;
              vsp_pkg::OP_START: begin
                play_mode     <= vsp_pkg::MODE_PROC;
                play_position <= '0;
              end
              vsp_pkg::OP_RENDER: begin
                if (play_mode == vsp_pkg::MODE_PROC && frames_c != '0) begin
                  state <= S_READ;
                end
              end
              default: ;
            endcase
          end
        end
        S_MUL_L: state <= S_MUL_R;
        S_MUL_R: begin
          left_scaled <= mul_result;
          state       <= S_WRITE;
        end
        S_WRITE: begin
          if (store_req.wr_en) begin
            load_address <= vsp_pkg::LOAD_W'(load_address + 1'b1);
          end
          state <= S_IDLE;
        end
        S_READ: begin
          ended <= past;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_acc) begin
            acc    <= acc_next;
            at_end <= at_end | ended;
            if (last_frame) begin
              if (at_end || ended) begin
                play_mode <= vsp_pkg::MODE_DONE;
              end else begin
                play_position <= vsp_pkg::POS_W'(play_position
                                                  + vsp_pkg::POS_W'(offs_next));
              end
              state <= S_IDLE;
            end else begin
              frame_cnt <= vsp_pkg::COUNT_W'(frame_cnt + 1'b1);
              state     <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input accepted while a frame is pending");

  a_ended_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("frame past the end carries data");

  a_end_finishes: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast && m_tuser) |=> (play_mode == vsp_pkg::MODE_DONE))
    else $error("block reached the end but player not finished");

  a_load_sat: assert property (@(posedge clk) disable iff (rst)
    load_address <= vsp_pkg::LOAD_W'(vsp_pkg::SAMPLE_DEPTH))
    else $error("load address beyond store depth");

  a_ended_sticky: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tuser && !m_tlast) |=> ##1 (m_tuser || !m_tvalid))
    else $error("frame after the end not marked ended");

endmodule
